@@ sv/sorted_pair_sum_two_pointer_assert.svh @@
// Assertion macros used by the sorted pair sum search RTL.
// Defining ASSERT_OFF turns every assertion into an empty statement.
// No dependencies.
`ifndef SORTED_PAIR_SUM_TWO_POINTER_ASSERT_SVH
`define SORTED_PAIR_SUM_TWO_POINTER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checks a property at every rising clock edge outside reset.
`define SPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Checks that a condition never holds outside reset.
`define SPS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define SPS_ASSERT(lbl, clk, rstn, prop, msg)
`define SPS_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

@@ sv/spsum_pkg.sv @@
// Shared types and constants of the sorted pair sum search.
// Used by the search sequencer and the top level. No dependencies.
package spsum_pkg;

  // Width of the reported 1-based positions.
  localparam int unsigned IDX_W = 11;
  // Width of the target sum register.
  localparam int unsigned TGT_W = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN
  } spsum_state_e;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] second_idx;
    logic             ovf;
  } spsum_result_t;

endpackage

@@ sv/spsum_ram.sv @@
// Generic synchronous RAM: one write port and two read ports, registered read data.
// No dependencies.
module spsum_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ sv/spsum_search.sv @@
// Two-pointer search sequencer: drives both RAM read ports, compares the pair sum
// with the target and registers the result. Depends on spsum_pkg and the assert macros.
`include "sorted_pair_sum_two_pointer_assert.svh"

module spsum_search
  import spsum_pkg::*;
#(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            go_i,
  input  logic [$clog2(DEPTH+1)-1:0]      count_i,
  input  logic                            ovf_i,
  input  logic signed [TGT_W-1:0]         target_i,
  input  logic signed [VALUE_WIDTH-1:0]   rd_a_i,
  input  logic signed [VALUE_WIDTH-1:0]   rd_b_i,
  output logic [$clog2(DEPTH)-1:0]        raddr_a_o,
  output logic [$clog2(DEPTH)-1:0]        raddr_b_o,
  output logic                            busy_o,
  output spsum_result_t                   result_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = (VALUE_WIDTH + 1 > TGT_W) ? VALUE_WIDTH + 1 : TGT_W;
  localparam int unsigned XW    = PTR_W + 1;

  spsum_state_e      state_q, state_d;
  logic [PTR_W-1:0]  l_q, l_d, r_q, r_d;
  logic              multi_q, multi_d;
  logic              ovf_q, ovf_d;
  spsum_result_t     res_q, res_d;

  logic signed [SUM_W-1:0] sum, tgt;
  logic [XW-1:0]           l_pos, r_pos;

  assign sum   = SUM_W'(rd_a_i) + SUM_W'(rd_b_i);
  assign tgt   = SUM_W'(target_i);
  assign l_pos = XW'(l_q) + XW'(1);
  assign r_pos = XW'(r_q) + XW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      l_q     <= '0;
      r_q     <= '0;
      multi_q <= 1'b0;
      ovf_q   <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      l_q     <= l_d;
      r_q     <= r_d;
      multi_q <= multi_d;
      ovf_q   <= ovf_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    l_d        = l_q;
    r_d        = r_q;
    multi_d    = multi_q;
    ovf_d      = ovf_q;
    res_d      = res_q;
    res_d.done = 1'b0;
    raddr_a_o  = l_q;
    raddr_b_o  = r_q;
    unique case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          l_d     = '0;
          r_d     = PTR_W'(count_i - CNT_W'(1));
          multi_d = count_i > CNT_W'(1);
          ovf_d   = ovf_i;
          state_d = ST_PRIME;
        end
      end
      ST_PRIME: begin
        // The read of the outermost pair is issued here when there is a pair at all.
        if (multi_q) begin
          state_d = ST_SCAN;
        end else begin
          res_d   = '{done: 1'b1, found: 1'b0, first_idx: '0, second_idx: '0, ovf: ovf_q};
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        priority if (sum == tgt) begin
          res_d = '{done: 1'b1, found: 1'b1, first_idx: IDX_W'(l_pos),
                    second_idx: IDX_W'(r_pos), ovf: ovf_q};
          state_d = ST_IDLE;
        end else begin
          if (sum > tgt) begin
            r_d = r_q - PTR_W'(1);
          end else begin
            l_d = l_q + PTR_W'(1);
          end
          // The next pair is fetched in the same cycle the step is decided.
          raddr_a_o = l_d;
          raddr_b_o = r_d;
          if (!(l_d < r_d)) begin
            res_d   = '{done: 1'b1, found: 1'b0, first_idx: '0, second_idx: '0, ovf: ovf_q};
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign result_o = res_q;

  `SPS_ASSERT(a_scan_ptr_order, clk_i, rst_ni, (state_q == ST_SCAN) |-> (l_q < r_q), "pointers crossed during scan")
  `SPS_ASSERT(a_go_primes, clk_i, rst_ni, (go_i && state_q == ST_IDLE) |=> (state_q == ST_PRIME), "search start did not prime")
  `SPS_ASSERT(a_done_single, clk_i, rst_ni, res_q.done |=> !res_q.done, "result strobe lasted more than one cycle")
  `SPS_ASSERT_NEVER(a_nf_zero_idx, clk_i, rst_ni, res_q.done && !res_q.found && (res_q.first_idx != '0 || res_q.second_idx != '0), "not-found result carries nonzero positions")

endmodule

@@ sv/sorted_pair_sum_two_pointer.sv @@
// Top level of the sorted pair sum search: load counter, target register,
// value RAM and search sequencer. Depends on spsum_pkg, spsum_ram and spsum_search.
//
// The block collects an ascending sorted list of signed values, one per start
// transaction, and the transaction with last_i high launches a two-pointer search for
// a pair whose sum equals the target register. Loading takes one value per cycle:
// start is taken whenever busy is low. The last transaction raises busy through the
// priming state and then one scan step per pair compared, at most count minus one
// pairs, until the pointers meet or a match is found. The step rate is set by the
// loop from the registered RAM read data through the sum compare back to the next
// read addresses. The result appears for exactly one cycle with done_o high in the
// same cycle busy falls; the receiver cannot stall it, so it must capture it then.
// Positions are 1-based and zero when no pair exists; overflow_o reports that values
// beyond DEPTH were dropped. The value RAM needs no clearing pass after reset, since
// every entry read belongs to the current list. The target may be written through the
// configuration channel at any time the block is idle; cfg_ready_o is always high.
module sorted_pair_sum_two_pointer
  import spsum_pkg::*;
#(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Item channel.
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          last_i,
  // Result channel.
  output logic                          done_o,
  output logic                          found_o,
  output logic [IDX_W-1:0]              first_index_o,
  output logic [IDX_W-1:0]              second_index_o,
  output logic                          overflow_o,
  // Configuration channel: target sum.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic signed [TGT_W-1:0]       cfg_data_i
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic signed [TGT_W-1:0] target_q;
  logic [CNT_W-1:0]        count_q, count_d, count_new;
  logic                    ovf_q, ovf_d, ovf_new;
  logic                    accept, store, go;

  logic [PTR_W-1:0]              raddr_a, raddr_b;
  logic signed [VALUE_WIDTH-1:0] rd_a, rd_b;
  spsum_result_t                 result;

  // A value is stored only while the RAM still has room; extras only set the flag.
  assign accept    = start && !busy;
  assign store     = accept && (count_q < CNT_W'(DEPTH));
  assign go        = accept && last_i;
  assign count_new = store ? count_q + CNT_W'(1) : count_q;
  assign ovf_new   = ovf_q | (accept && !store);

  // The list bookkeeping restarts as soon as the search is handed the final count.
  always_comb begin
    count_d = count_new;
    ovf_d   = ovf_new;
    if (go) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        target_q <= cfg_data_i;
      end
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  spsum_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (store),
    .waddr_i   (count_q[PTR_W-1:0]),
    .wdata_i   (value_i),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rd_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rd_b)
  );

  spsum_search #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (go),
    .count_i   (count_new),
    .ovf_i     (ovf_new),
    .target_i  (target_q),
    .rd_a_i    (rd_a),
    .rd_b_i    (rd_b),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .busy_o    (busy),
    .result_o  (result)
  );

  assign done_o         = result.done;
  assign found_o        = result.found;
  assign first_index_o  = result.first_idx;
  assign second_index_o = result.second_idx;
  assign overflow_o     = result.ovf;

endmodule
